// ===== rtl/core/rwtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwtc_pkg
// Shared constants, queue entry and divider control types and the dimension
// clamp helper of the wall texture column unit.
// ----------------------------------------------------------------------------
package rwtc_pkg;

  localparam int SCREEN_H   = 1024;
  localparam int ROW_W      = 10;
  localparam int CNT_ROW_W  = ROW_W + 1;
  localparam int COL_W      = 12;
  localparam int POS_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int CELL_W     = 8;
  localparam int RAY_W      = 20;
  localparam int DIST_W     = 26;
  localparam int LH_W       = 16;
  localparam int DIM_W      = 13;
  localparam int TEXC_W     = 12;
  localparam int OFS_W      = 24;
  localparam int TPOS_W     = 40;
  localparam int A_W        = LH_W + 1;
  localparam int DIVD_W     = DIM_W + FRAC_W;
  localparam int STEP_W     = DIVD_W;
  localparam int NUM_TEX    = 4;
  localparam int TEX_W      = $clog2(NUM_TEX);
  localparam int CFG_IDX_W  = $clog2(2 * NUM_TEX);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [DIM_W-1:0] TEX_DIM_RST = DIM_W'(64);
  localparam logic [DIM_W-1:0] TEX_DIM_MIN = DIM_W'(1);
  localparam logic [DIM_W-1:0] TEX_DIM_MAX = DIM_W'(4096);
  localparam logic [LH_W-1:0]  LH_MIN      = LH_W'(1);
  localparam logic signed [A_W-1:0] HALF_SCREEN = A_W'(SCREEN_H / 2);

  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef logic [NUM_TEX-1:0][DIM_W-1:0] dim_arr_t;

  typedef struct packed {
    logic                     op;
    logic                     tex_upd;
    logic [TEX_W-1:0]         tex_val;
    logic                     mirror;
    logic                     empty;
    logic [FRAC_W-1:0]        pos_lo;
    logic [DIST_W-1:0]        wall_dist;
    logic signed [RAY_W-1:0]  ray;
    logic [LH_W-1:0]          line_height;
    logic signed [A_W-1:0]    row_ofs;
    logic [ROW_W-1:0]         first_row;
    logic [ROW_W-1:0]         last_row;
    logic [COL_W-1:0]         column;
  } entry_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = TEX_DIM_MIN;
    else if (v > TEX_DIM_MAX) r = TEX_DIM_MAX;
    return r;
  endfunction

endpackage

// ===== rtl/core/rwtc_front.sv =====
// ----------------------------------------------------------------------------
// rwtc_front
// Input side: takes items while the queue has room and classifies column
// starts (texture choice, mirror rule, axis selection, row offset).
// ----------------------------------------------------------------------------
module rwtc_front
  import rwtc_pkg::*;
(
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic                    hit_side_i,
  input  logic [POS_W-1:0]        player_x_i,
  input  logic [POS_W-1:0]        player_y_i,
  input  logic [CELL_W-1:0]       hit_cell_i,
  input  logic signed [RAY_W-1:0] ray_dx_i,
  input  logic signed [RAY_W-1:0] ray_dy_i,
  input  logic [DIST_W-1:0]       wall_dist_i,
  input  logic [LH_W-1:0]         line_height_i,
  input  logic [ROW_W-1:0]        first_row_i,
  input  logic [ROW_W-1:0]        last_row_i,
  input  logic [COL_W-1:0]        screen_column_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output entry_t                  entry_o
);

  logic [POS_W-1:0] cell_pos;
  logic [POS_W-1:0] axis_pos;
  logic             pos_gt;
  logic             pos_lt;
  logic [LH_W-1:0]  lh;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign cell_pos = {hit_cell_i, FRAC_W'(0)};
  assign axis_pos = hit_side_i ? player_y_i : player_x_i;
  assign pos_gt   = axis_pos > cell_pos;
  assign pos_lt   = axis_pos < cell_pos;
  assign lh       = (line_height_i == '0) ? LH_MIN : line_height_i;

  always_comb begin
    entry_o.op          = op_i;
    entry_o.tex_upd     = pos_gt || pos_lt;
    entry_o.tex_val     = {hit_side_i, pos_lt};
    entry_o.mirror      = hit_side_i ? ray_dy_i[RAY_W-1]
                                     : (!ray_dx_i[RAY_W-1] && (ray_dx_i != '0));
    entry_o.empty       = first_row_i > last_row_i;
    entry_o.pos_lo      = hit_side_i ? player_x_i[FRAC_W-1:0] : player_y_i[FRAC_W-1:0];
    entry_o.wall_dist   = wall_dist_i;
    entry_o.ray         = hit_side_i ? ray_dx_i : ray_dy_i;
    entry_o.line_height = lh;
    entry_o.row_ofs     = $signed({{(A_W-ROW_W){1'b0}}, first_row_i}) - HALF_SCREEN
                          + $signed({2'b00, lh[LH_W-1:1]});
    entry_o.first_row   = first_row_i;
    entry_o.last_row    = last_row_i;
    entry_o.column      = screen_column_i;
  end

endmodule

// ===== rtl/core/rwtc_queue.sv =====
// ----------------------------------------------------------------------------
// rwtc_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module rwtc_queue
  import rwtc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

// ===== rtl/core/rwtc_div.sv =====
// ----------------------------------------------------------------------------
// rwtc_div
// Radix-2 restoring divider for the texture step, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rwtc_div
  import rwtc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctl_t          ctl_i,
  output div_ctl_t          ctl_o,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [LH_W-1:0]   divisor_i,
  output logic [STEP_W-1:0] quotient_o
);

  localparam int STEPS_W = $clog2(DIVD_W + 1);
  localparam logic [STEPS_W-1:0] DIV_STEPS = STEPS_W'(DIVD_W);

  logic [DIVD_W-1:0]  quo_q;
  logic [LH_W-1:0]    rem_q;
  logic [LH_W-1:0]    dsr_q;
  logic [STEPS_W-1:0] cnt_q;
  logic               busy_q;
  logic [LH_W:0]      shifted;
  logic [LH_W:0]      trial;
  logic               q_bit;
  logic [LH_W-1:0]    rem_d;

  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign q_bit   = !trial[LH_W];
  assign rem_d   = q_bit ? trial[LH_W-1:0] : shifted[LH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_STEPS;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEPS_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  always_comb begin
    ctl_o.start = ctl_i.start;
    ctl_o.busy  = busy_q;
  end

  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/rwtc_back.sv =====
// ----------------------------------------------------------------------------
// rwtc_back
// Execution side: column setup sequencer and per-pixel texel address path
// with the output register.
// ----------------------------------------------------------------------------
module rwtc_back
  import rwtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  entry_t             head_i,
  output logic               pop_o,
  input  dim_arr_t           tex_w_i,
  input  dim_arr_t           tex_h_i,
  output div_ctl_t           div_ctl_o,
  input  div_ctl_t           div_ctl_i,
  output logic [DIVD_W-1:0]  div_dividend_o,
  output logic [LH_W-1:0]    div_divisor_o,
  input  logic [STEP_W-1:0]  div_quotient_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COL_W-1:0]   pixel_column_o,
  output logic [ROW_W-1:0]   pixel_row_o,
  output logic [TEX_W-1:0]   texture_index_o,
  output logic [OFS_W-1:0]   texel_offset_o,
  output logic               column_done_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FRAC = 3'd1;
  localparam logic [2:0] ST_COL  = 3'd2;
  localparam logic [2:0] ST_MIRR = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_POS  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [TEX_W-1:0]         cur_tex_q;
  logic                     active_q;
  logic                     mirror_q;
  logic                     empty_q;
  logic [FRAC_W-1:0]        pos_lo_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [RAY_W-1:0]  ray_q;
  logic signed [A_W-1:0]    row_ofs_q;
  logic [31:0]              frac_q;
  logic [TEXC_W-1:0]        col_raw_q;
  logic [TEXC_W-1:0]        tex_col_q;
  logic [STEP_W-1:0]        step_q;
  logic [TPOS_W-1:0]        tex_pos_q;
  logic [CNT_ROW_W-1:0]     cur_row_q;
  logic [ROW_W-1:0]         end_row_q;
  logic [COL_W-1:0]         cur_col_q;
  logic                     out_valid_q;

  logic                     idle;
  logic                     pop_start;
  logic                     pop_pix;
  logic                     emit;
  logic                     out_free;
  logic [TEX_W-1:0]         tex_sel;
  logic [DIM_W-1:0]         w_sel;
  logic [DIM_W-1:0]         h_sel;
  logic [TEXC_W-1:0]        h_mask;
  logic [TEXC_W-1:0]        tex_row;
  logic [TEXC_W+DIM_W-1:0]  row_prod;
  logic [TEXC_W+DIM_W-1:0]  ofs_sum;
  logic                     done;
  logic signed [46:0]       frac_prod;
  logic [31:0]              frac_d;
  logic [31+DIM_W:0]        col_prod;
  logic [DIM_W-1:0]         mirr_col;
  logic signed [46:0]       pos_prod;

  assign idle      = state_q == ST_IDLE;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_start = idle && q_valid_i && (head_i.op == OP_START);
  assign pop_pix   = idle && q_valid_i && (head_i.op == OP_PIXEL) && out_free;
  assign pop_o     = pop_start || pop_pix;
  assign emit      = pop_pix && active_q;

  assign tex_sel = (pop_start && head_i.tex_upd) ? head_i.tex_val : cur_tex_q;
  assign w_sel   = clamp_dim(tex_w_i[tex_sel]);
  assign h_sel   = clamp_dim(tex_h_i[tex_sel]);
  assign h_mask  = TEXC_W'(h_sel - TEX_DIM_MIN);

  assign div_ctl_o.start = pop_start;
  assign div_ctl_o.busy  = 1'b0;
  assign div_dividend_o  = {h_sel, FRAC_W'(0)};
  assign div_divisor_o   = head_i.line_height;

  assign tex_row  = tex_pos_q[FRAC_W +: TEXC_W] & h_mask;
  assign row_prod = tex_row * w_sel;
  assign ofs_sum  = row_prod + {{DIM_W{1'b0}}, tex_col_q};
  assign done     = cur_row_q >= {1'b0, end_row_q};

  assign frac_prod = $signed({1'b0, dist_q}) * ray_q;
  assign frac_d    = {pos_lo_q, FRAC_W'(0)} + frac_prod[31:0];
  assign col_prod  = frac_q * w_sel;
  assign mirr_col  = w_sel - TEX_DIM_MIN - {1'b0, col_raw_q};
  assign pos_prod  = row_ofs_q * $signed({1'b0, step_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop_start) state_d = ST_FRAC;
      ST_FRAC: state_d = ST_COL;
      ST_COL:  state_d = ST_MIRR;
      ST_MIRR: state_d = ST_DIV;
      ST_DIV:  if (!div_ctl_i.busy) state_d = ST_POS;
      ST_POS:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_tex_q   <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_start) begin
        cur_tex_q <= tex_sel;
        active_q  <= 1'b0;
      end
      if (emit && done) active_q <= 1'b0;
      if (state_q == ST_POS) active_q <= !empty_q;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_start) begin
      mirror_q  <= head_i.mirror;
      empty_q   <= head_i.empty;
      pos_lo_q  <= head_i.pos_lo;
      dist_q    <= head_i.wall_dist;
      ray_q     <= head_i.ray;
      row_ofs_q <= head_i.row_ofs;
      cur_row_q <= {1'b0, head_i.first_row};
      end_row_q <= head_i.last_row;
      cur_col_q <= head_i.column;
    end
    if (state_q == ST_FRAC) frac_q <= frac_d;
    if (state_q == ST_COL) col_raw_q <= col_prod[32 +: TEXC_W];
    if (state_q == ST_MIRR) tex_col_q <= mirror_q ? mirr_col[TEXC_W-1:0] : col_raw_q;
    if (state_q == ST_DIV) step_q <= div_quotient_i;
    if (state_q == ST_POS) tex_pos_q <= pos_prod[TPOS_W-1:0];
    if (emit) begin
      pixel_column_o  <= cur_col_q;
      pixel_row_o     <= cur_row_q[ROW_W-1:0];
      texture_index_o <= cur_tex_q;
      texel_offset_o  <= ofs_sum[OFS_W-1:0];
      column_done_o   <= done;
      tex_pos_q       <= tex_pos_q + {{(TPOS_W-STEP_W){1'b0}}, step_q};
      cur_row_q       <= cur_row_q + 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/raycast_wall_texture_column_unit.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_texture_column_unit
// Wall texture column generator: column setup and per-pixel texel offsets.
// ----------------------------------------------------------------------------
// Input words (in_valid_i / in_stall_o) carry either a column start (op 0)
// with the ray hit data or a pixel request (op 1). Output words
// (out_valid_o / out_stall_i) carry one pixel: screen column and row,
// texture index, texel offset and a flag on the last pixel of the column.
// Texture sizes sit in eight registers written on the cfg port, which is
// always ready; write them only while no item is in flight.
// Input words enter a two-entry queue; the input stalls only when it is
// full. A pixel request's word passes through the queue and the output
// register; the unit sustains one pixel per cycle while the output is not
// stalled and no column start is in setup. A column start holds the back
// end while it pops, runs the bit-serial step divider (one quotient bit a
// cycle), hands the step over and does the start position multiply; the
// wall hit, texture column and mirror stages run beside the divider.
// Requests behind a start wait in the queue. Start items and pixel
// requests without an active column give no word. While out_stall_i is
// high a valid output word holds and pixel requests wait. Reset clears
// the queue, active column and texture choice, and sets all sizes to 64.
// ----------------------------------------------------------------------------
module raycast_wall_texture_column_unit
  import rwtc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic                    hit_side_i,
  input  logic [POS_W-1:0]        player_x_i,
  input  logic [POS_W-1:0]        player_y_i,
  input  logic [CELL_W-1:0]       hit_cell_i,
  input  logic signed [RAY_W-1:0] ray_dx_i,
  input  logic signed [RAY_W-1:0] ray_dy_i,
  input  logic [DIST_W-1:0]       wall_dist_i,
  input  logic [LH_W-1:0]         line_height_i,
  input  logic [ROW_W-1:0]        first_row_i,
  input  logic [ROW_W-1:0]        last_row_i,
  input  logic [COL_W-1:0]        screen_column_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COL_W-1:0]        pixel_column_o,
  output logic [ROW_W-1:0]        pixel_row_o,
  output logic [TEX_W-1:0]        texture_index_o,
  output logic [OFS_W-1:0]        texel_offset_o,
  output logic                    column_done_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [DIM_W-1:0]        cfg_data_i
);

  dim_arr_t          tex_w_q;
  dim_arr_t          tex_h_q;
  logic              q_full;
  logic              q_push;
  entry_t            q_entry;
  logic              q_valid;
  logic              q_pop;
  entry_t            q_head;
  div_ctl_t          div_req;
  div_ctl_t          div_rsp;
  logic [DIVD_W-1:0] div_dividend;
  logic [LH_W-1:0]   div_divisor;
  logic [STEP_W-1:0] div_quotient;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TEX; i++) begin
        tex_w_q[i] <= TEX_DIM_RST;
        tex_h_q[i] <= TEX_DIM_RST;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i[CFG_IDX_W-1]) tex_h_q[cfg_index_i[TEX_W-1:0]] <= cfg_data_i;
      else tex_w_q[cfg_index_i[TEX_W-1:0]] <= cfg_data_i;
    end
  end

  rwtc_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .hit_side_i      (hit_side_i),
    .player_x_i      (player_x_i),
    .player_y_i      (player_y_i),
    .hit_cell_i      (hit_cell_i),
    .ray_dx_i        (ray_dx_i),
    .ray_dy_i        (ray_dy_i),
    .wall_dist_i     (wall_dist_i),
    .line_height_i   (line_height_i),
    .first_row_i     (first_row_i),
    .last_row_i      (last_row_i),
    .screen_column_i (screen_column_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .entry_o         (q_entry)
  );

  rwtc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  rwtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_req),
    .ctl_o      (div_rsp),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient)
  );

  rwtc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .tex_w_i         (tex_w_q),
    .tex_h_i         (tex_h_q),
    .div_ctl_o       (div_req),
    .div_ctl_i       (div_rsp),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_quotient_i  (div_quotient),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_column_o  (pixel_column_o),
    .pixel_row_o     (pixel_row_o),
    .texture_index_o (texture_index_o),
    .texel_offset_o  (texel_offset_o),
    .column_done_o   (column_done_o)
  );

endmodule

// ===== rtl/core/rwtc_checker.sv =====
// ----------------------------------------------------------------------------
// rwtc_checker
// Port-level checks of the wall texture column unit, bound to the top level.
// ----------------------------------------------------------------------------
module rwtc_checker
  import rwtc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COL_W-1:0]   pixel_column_o,
  input logic [ROW_W-1:0]   pixel_row_o,
  input logic [TEX_W-1:0]   texture_index_o,
  input logic [OFS_W-1:0]   texel_offset_o,
  input logic               column_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_column_o) && $stable(pixel_row_o)
      && $stable(texture_index_o) && $stable(texel_offset_o) && $stable(column_done_o))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without a queued word");

  a_last_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pixel_row_o == {ROW_W{1'b1}}) |-> column_done_o)
    else $error("pixel on the bottom row not marked as last");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

endmodule

bind raycast_wall_texture_column_unit rwtc_checker u_rwtc_checker (.*);
